// ===== hw/rtl/sfg_pkg.sv =====
// ----------------------------------------------------------------------------
// sfg_pkg: spring force generator shared types
// Payload structs, register codes and pipeline records for the spring force
// datapath.
// ----------------------------------------------------------------------------
package sfg_pkg;

  localparam int FRAC_DEF   = 16;  // default fraction bits (Q16.16)
  localparam int FRAC_MAX   = 24;
  localparam int QUO_W      = FRAC_MAX + 1;  // unit vector component, up to 2^F
  localparam int LEN_W      = 33;
  localparam int RAD_W      = 66;
  localparam int SQ_STEPS   = 33;
  localparam int SQ_REM_W   = 34;
  localparam int DIV_REM_W  = 33;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_SPRING_K = 3'd1,
    REG_REST_LEN = 3'd2,
    REG_ANCHOR_X = 3'd3,
    REG_ANCHOR_Y = 3'd4
  } sfg_reg_e;

  typedef enum logic [1:0] {
    MODE_PARTNER = 2'd0,
    MODE_ANCHOR  = 2'd1,
    MODE_BUNGEE  = 2'd2
  } sfg_mode_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] partner_x;
    logic signed [31:0] partner_y;
  } sfg_in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               applied;
    logic               saturated;
  } sfg_out_t;

  // separation magnitudes and signs, carried along the root chain
  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic        x_pos;
    logic        y_pos;
  } sfg_vec_t;

  typedef struct packed {
    logic [RAD_W-1:0]    rad;
    logic [SQ_REM_W-1:0] rem;
    logic [LEN_W-1:0]    root;
    sfg_vec_t            side;
  } sfg_sq_t;

  typedef struct packed {
    logic [DIV_REM_W-1:0] rem;
    logic [QUO_W-1:0]     quo;
    logic                 nb;    // next dividend bit
  } sfg_lane_t;

  typedef struct packed {
    sfg_lane_t        lx;
    sfg_lane_t        ly;
    logic [LEN_W-1:0] len;
    logic [63:0]      mag;
    logic             x_pos;
    logic             y_pos;
    logic             apply;
  } sfg_div_t;

endpackage

// ===== hw/rtl/spring_force_generator.sv =====
// ----------------------------------------------------------------------------
// spring_force_generator: 2D Hooke's-law spring force pipeline
// Separation, exact integer length, stretch times stiffness, direction by
// division, then per-component scaling with saturation.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: drive item_i and raise start; the transfer happens on a clock
//    edge with start high and busy low. busy stays low, so one item can be
//    taken every cycle.
//  - Result: result_o is shown for exactly one cycle with result_valid_o
//    high. Results leave in input order. The receiver cannot stall; it must
//    take the result in that cycle.
//  - Pipeline: the root chain (33 cells, one digit each) and the divider
//    chain (FRAC_BITS + 1 cells), plus 7 register stages.
//  - Config: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i.
//    cfg_ready_o is always high. Write only while no items are in flight.
//  - Reset (rst_ni low, async) empties the pipeline and restores the
//    register defaults: partner mode, k = 1.0 and rest length = 1.0 in Q16.16, anchor 0.
// ----------------------------------------------------------------------------
module spring_force_generator #(
  parameter int FRAC_BITS = sfg_pkg::FRAC_DEF  // 8..24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  sfg_pkg::sfg_in_t                 item_i,
  output logic                             result_valid_o,
  output sfg_pkg::sfg_out_t                result_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sfg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sfg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import sfg_pkg::*;

  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int LAT       = 41 + FRAC_BITS;
  localparam int PROD_W    = 32 + QUO_W;

  // -------- configuration registers --------
  sfg_mode_e   mode_q;
  logic [30:0] k_q, rest_q;
  logic [31:0] anc_x_q, anc_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PARTNER;
      k_q     <= 31'd65536;
      rest_q  <= 31'd65536;
      anc_x_q <= '0;
      anc_y_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (sfg_reg_e'(cfg_index_i))
        REG_MODE:     mode_q  <= sfg_mode_e'(cfg_data_i[1:0]);
        REG_SPRING_K: k_q     <= cfg_data_i[30:0];
        REG_REST_LEN: rest_q  <= cfg_data_i[30:0];
        REG_ANCHOR_X: anc_x_q <= cfg_data_i;
        REG_ANCHOR_Y: anc_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  // -------- stage A: separation --------
  logic        a_v_q;
  logic [32:0] dx_q, dy_q;
  logic [31:0] qx, qy;

  always_comb begin
    if (mode_q == MODE_ANCHOR) begin
      qx = anc_x_q;
      qy = anc_y_q;
    end else begin
      qx = item_i.partner_x;
      qy = item_i.partner_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else begin
      a_v_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= {item_i.pos_x[31], item_i.pos_x} - {qx[31], qx};
    dy_q <= {item_i.pos_y[31], item_i.pos_y} - {qy[31], qy};
  end

  // -------- stage B: magnitudes and squares --------
  logic        b_v_q;
  logic [63:0] sx_q, sy_q;
  sfg_vec_t    b_vec_q;
  logic [31:0] abs_x, abs_y;

  assign abs_x = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
  assign abs_y = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q          <= abs_x * abs_x;
    sy_q          <= abs_y * abs_y;
    b_vec_q.ax    <= abs_x;
    b_vec_q.ay    <= abs_y;
    b_vec_q.x_pos <= !dx_q[32] && (dx_q != '0);
    b_vec_q.y_pos <= !dy_q[32] && (dy_q != '0);
  end

  // -------- stage C: squared length, feeds the root chain --------
  logic    sq_v [0:SQ_STEPS];
  sfg_sq_t sq_d [0:SQ_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v[0] <= 1'b0;
    end else begin
      sq_v[0] <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_d[0].rad  <= RAD_W'(sx_q) + RAD_W'(sy_q);
    sq_d[0].rem  <= '0;
    sq_d[0].root <= '0;
    sq_d[0].side <= b_vec_q;
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    sfg_sqrt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (sq_v[i]),
      .d_i   (sq_d[i]),
      .vld_o (sq_v[i+1]),
      .d_o   (sq_d[i+1])
    );
  end

  // -------- stage M1: stretch and low stiffness product --------
  logic             m1_v_q;
  logic [62:0]      m1_prod_q;
  logic             m1_eh_q, m1_apply_q;
  logic [LEN_W-1:0] m1_len_q;
  sfg_vec_t         m1_vec_q;
  logic [LEN_W-1:0] len_w, rest_w, ext;
  logic             slack;

  assign len_w  = sq_d[SQ_STEPS].root;
  assign rest_w = LEN_W'(rest_q);
  assign ext    = (len_w >= rest_w) ? (len_w - rest_w) : (rest_w - len_w);
  // bungee goes slack at or below rest length
  assign slack  = (mode_q == MODE_BUNGEE) && (len_w <= rest_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else begin
      m1_v_q <= sq_v[SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    m1_prod_q  <= k_q * ext[31:0];
    m1_eh_q    <= ext[32];
    m1_apply_q <= (len_w != '0) && !slack;
    m1_len_q   <= len_w;
    m1_vec_q   <= sq_d[SQ_STEPS].side;
  end

  // -------- stage M2: force magnitude, feeds the divider chain --------
  logic     dv_v [0:DIV_STEPS];
  sfg_div_t dv_d [0:DIV_STEPS];
  logic [63:0] kh;

  assign kh = m1_eh_q ? {1'b0, k_q, 32'd0} : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v[0] <= 1'b0;
    end else begin
      dv_v[0] <= m1_v_q;
    end
  end

  // dividend is |d| << F; the first bit in is |d|[0], then zeros
  always_ff @(posedge clk_i) begin
    dv_d[0].mag    <= (kh + 64'(m1_prod_q)) >> FRAC_BITS;
    dv_d[0].len    <= m1_len_q;
    dv_d[0].x_pos  <= m1_vec_q.x_pos;
    dv_d[0].y_pos  <= m1_vec_q.y_pos;
    dv_d[0].apply  <= m1_apply_q;
    dv_d[0].lx.rem <= DIV_REM_W'(m1_vec_q.ax >> 1);
    dv_d[0].lx.nb  <= m1_vec_q.ax[0];
    dv_d[0].lx.quo <= '0;
    dv_d[0].ly.rem <= DIV_REM_W'(m1_vec_q.ay >> 1);
    dv_d[0].ly.nb  <= m1_vec_q.ay[0];
    dv_d[0].ly.quo <= '0;
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    sfg_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (dv_v[j]),
      .d_i   (dv_d[j]),
      .vld_o (dv_v[j+1]),
      .d_o   (dv_d[j+1])
    );
  end

  // -------- stage P1: magnitude times unit vector, split products --------
  logic              p_v_q;
  logic [PROD_W-1:0] phx_q, plx_q, phy_q, ply_q;
  logic              p_xpos_q, p_ypos_q, p_apply_q;
  sfg_div_t          dv_end;

  assign dv_end = dv_d[DIV_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else begin
      p_v_q <= dv_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    phx_q     <= dv_end.mag[63:32] * dv_end.lx.quo;
    plx_q     <= dv_end.mag[31:0]  * dv_end.lx.quo;
    phy_q     <= dv_end.mag[63:32] * dv_end.ly.quo;
    ply_q     <= dv_end.mag[31:0]  * dv_end.ly.quo;
    p_xpos_q  <= dv_end.x_pos;
    p_ypos_q  <= dv_end.y_pos;
    p_apply_q <= dv_end.apply;
  end

  // -------- stage P2: combine, sign and saturate --------
  function automatic logic [32:0] finish(logic [PROD_W-1:0] ph, logic [PROD_W-1:0] pl,
                                         logic pos);
    logic        big;
    logic [34:0] m;
    logic [31:0] v;
    logic        sat;
    big = (ph >> FRAC_BITS) != '0;
    m   = (35'(ph) << (32 - FRAC_BITS)) + 35'(pl >> FRAC_BITS);
    if (pos) begin
      sat = big || (m > 35'h0_8000_0000);
      v   = sat ? 32'h8000_0000 : 32'(-m);
    end else begin
      sat = big || (m > 35'h0_7FFF_FFFF);
      v   = sat ? 32'h7FFF_FFFF : m[31:0];
    end
    return {sat, v};
  endfunction

  logic [32:0] fx, fy;
  sfg_out_t    res_d, res_q;
  logic        res_v_q;

  always_comb begin
    fx = finish(phx_q, plx_q, p_xpos_q);
    fy = finish(phy_q, ply_q, p_ypos_q);
    if (p_apply_q) begin
      res_d.force_x   = fx[31:0];
      res_d.force_y   = fy[31:0];
      res_d.applied   = 1'b1;
      res_d.saturated = fx[32] || fy[32];
    end else begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

`ifndef NO_ASSERTIONS
  // no force means all-zero result
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.applied |->
      result_o.force_x == '0 && result_o.force_y == '0 && !result_o.saturated)
    else $error("unapplied result carries force");

  a_sat_applied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.saturated |-> result_o.applied)
    else $error("saturation flagged without force");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LAT))
    else $error("result without matching input transfer");
`endif

endmodule

// ===== hw/rtl/sfg_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// sfg_sqrt_cell: one digit step of the square root chain
// Takes two radicand bits, tries the next root bit, registers the result.
// ----------------------------------------------------------------------------
module sfg_sqrt_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  sfg_pkg::sfg_sq_t d_i,
  output logic             vld_o,
  output sfg_pkg::sfg_sq_t d_o
);
  import sfg_pkg::*;

  logic [SQ_REM_W+1:0] rn;
  logic [SQ_REM_W+1:0] trial;
  logic                ge;
  sfg_sq_t             d_d, d_q;
  logic                vld_q;

  always_comb begin
    rn    = {d_i.rem, d_i.rad[RAD_W-1 -: 2]};
    trial = (SQ_REM_W+2)'({d_i.root, 2'b01});
    ge    = (rn >= trial);
    d_d      = d_i;
    d_d.rem  = ge ? SQ_REM_W'(rn - trial) : rn[SQ_REM_W-1:0];
    d_d.root = {d_i.root[LEN_W-2:0], ge};
    d_d.rad  = {d_i.rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
  end

  assign vld_o = vld_q;
  assign d_o   = d_q;

endmodule

// ===== hw/rtl/sfg_div_cell.sv =====
// ----------------------------------------------------------------------------
// sfg_div_cell: one quotient bit of the direction divider
// Restoring step for both x and y lanes against the shared length.
// ----------------------------------------------------------------------------
module sfg_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  sfg_pkg::sfg_div_t d_i,
  output logic              vld_o,
  output sfg_pkg::sfg_div_t d_o
);
  import sfg_pkg::*;

  sfg_div_t d_d, d_q;
  logic     vld_q;

  function automatic sfg_lane_t lane_step(sfg_lane_t l, logic [LEN_W-1:0] len);
    logic [DIV_REM_W:0] t;
    logic               ge;
    sfg_lane_t          r;
    t     = {l.rem, l.nb};
    ge    = (t >= {1'b0, len});
    r.rem = ge ? DIV_REM_W'(t - {1'b0, len}) : t[DIV_REM_W-1:0];
    r.quo = {l.quo[QUO_W-2:0], ge};
    r.nb  = 1'b0;
    return r;
  endfunction

  always_comb begin
    d_d    = d_i;
    d_d.lx = lane_step(d_i.lx, d_i.len);
    d_d.ly = lane_step(d_i.ly, d_i.len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
  end

  assign vld_o = vld_q;
  assign d_o   = d_q;

endmodule
